@@ rtl/core/rtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and codes of the regulator trim calibrator
// Field widths, opcodes, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

    // field widths fixed by the word format
    localparam int unsigned CODE_W   = 5;
    localparam int unsigned REG_W    = 4;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned HIST_W   = 4;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    typedef logic [CODE_W-1:0]    t_code;
    typedef logic [REG_W-1:0]     t_reg;
    typedef logic [STAT_W-1:0]    t_status;
    typedef logic [HIST_W-1:0]    t_hist;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0] t_cfg_dat;

    // opcodes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // result status codes
    localparam t_status ST_RUN     = 3'd0;
    localparam t_status ST_PASS    = 3'd1;
    localparam t_status ST_FAIL    = 3'd2;
    localparam t_status ST_BYPASS  = 3'd3;
    localparam t_status ST_IGNORED = 3'd4;

    // configuration register indexes
    localparam t_cfg_idx CFG_START_CODE = 2'd0;
    localparam t_cfg_idx CFG_RUN_LIMIT  = 2'd1;
    localparam t_cfg_idx CFG_CONT_MODE  = 2'd2;
    localparam t_cfg_idx CFG_BYPASS_EXT = 2'd3;

    // configuration reset values
    localparam t_code  RST_START_CODE = 5'd4;
    localparam t_count RST_RUN_LIMIT  = 8'd64;

    // alternating decision patterns that mark dither around the target
    localparam t_hist DITHER_A = 4'hA;
    localparam t_hist DITHER_B = 4'h5;

    // result word
    typedef struct packed {
        t_reg    regulator_out;
        t_code   trim_code;
        t_status status;
    } t_result;

endpackage : rtc_pkg

`default_nettype wire

@@ rtl/core/regulator_trim_calibrator.sv @@
// ----------------------------------------------------------------------------
// regulator_trim_calibrator: up/down trim code search for one regulator
// A start word loads the start code, or reports bypass; each comparator word
// in a search steps the code: running, pass on dither, fail on limit or in cont mode; other words are ignored.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       to block   i_in_valid / o_in_stall   i_opcode, i_regulator,
//                                                i_comparator_high
//  out      from block o_out_valid / i_out_stall o_regulator_out, o_trim_code,
//                                                o_status
//  cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
//  Each word gives exactly one result, held first in the input register and
//  then in the result register. A new word is accepted in every cycle while
//  o_in_stall is low; the calibration state updates as a word moves from the
//  input register to the result register.
//  Reset (i_rst_n low, synchronous) empties both registers and loads the
//  register defaults. A stall on the output holds the result register, and
//  holds the input register too once it has a word; only then does
//  o_in_stall rise.
// ----------------------------------------------------------------------------
`default_nettype none

module regulator_trim_calibrator
    import rtc_pkg::*;
#(
    parameter int unsigned CODE_MAX       = 31,
    parameter int unsigned NUM_REGULATORS = 12
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // input words
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire logic     i_opcode,
    input  wire t_reg     i_regulator,
    input  wire logic     i_comparator_high,
    // result words
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_reg          o_regulator_out,
    output t_code         o_trim_code,
    output t_status       o_status,
    // configuration writes
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_cfg_dat i_cfg_data
);

    // top code clipped to the code width
    localparam t_code TOP_CODE = (CODE_MAX > 31) ? 5'd31 : CODE_MAX[CODE_W-1:0];
    localparam logic [REG_W:0] NUM_REG = NUM_REGULATORS[REG_W:0];

    // configuration registers
    t_code  r_start_code;
    t_count r_run_limit;
    logic   r_cont_mode;
    logic   r_bypass_ext;

    // calibration state
    logic   r_busy,  n_busy;
    t_code  r_code,  n_code;
    t_hist  r_hist,  n_hist;
    t_count r_count, n_count;
    t_reg   r_active, n_active;

    // input register
    logic   r_s1_valid;
    logic   r_s1_opcode;
    t_reg   r_s1_reg;
    logic   r_s1_high;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic  out_stall;
    logic  s1_move;
    t_code start_clip;
    t_hist hist_shift;
    t_code code_step;

    // hold both stages while the result waits
    assign out_stall  = r_out_valid && i_out_stall;
    assign o_in_stall = r_s1_valid && out_stall;
    assign s1_move    = r_s1_valid && !out_stall;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= RST_START_CODE;
            r_run_limit  <= RST_RUN_LIMIT;
            r_cont_mode  <= 1'b0;
            r_bypass_ext <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_CODE: r_start_code <= i_cfg_data[CODE_W-1:0];
                CFG_RUN_LIMIT:  r_run_limit  <= i_cfg_data;
                CFG_CONT_MODE:  r_cont_mode  <= i_cfg_data[0];
                CFG_BYPASS_EXT: r_bypass_ext <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_opcode <= i_opcode;
            r_s1_reg    <= i_regulator;
            r_s1_high   <= i_comparator_high;
        end
    end

    // step the search for the word in the input register
    assign start_clip = (r_start_code > TOP_CODE) ? TOP_CODE : r_start_code;
    assign hist_shift = {r_hist[HIST_W-2:0], r_s1_high};
    always_comb begin
        code_step = r_code;
        if (r_s1_high) begin
            if (r_code != '0) code_step = r_code - 1'b1;
        end else begin
            if (r_code < TOP_CODE) code_step = r_code + 1'b1;
        end
    end

    always_comb begin
        n_busy   = r_busy;
        n_code   = r_code;
        n_hist   = r_hist;
        n_count  = r_count;
        n_active = r_active;
        n_out    = '{regulator_out: '0, trim_code: '0, status: ST_IGNORED};
        if (r_s1_opcode == OP_START) begin
            if ({1'b0, r_s1_reg} < NUM_REG) begin
                n_active = r_s1_reg;
                if (r_bypass_ext) begin
                    n_busy = 1'b0;
                    n_out  = '{regulator_out: r_s1_reg, trim_code: '0, status: ST_BYPASS};
                end else begin
                    n_busy  = 1'b1;
                    n_code  = start_clip;
                    n_hist  = '0;
                    n_count = '0;
                    n_out   = '{regulator_out: r_s1_reg, trim_code: start_clip,
                                status: ST_RUN};
                end
            end
        end else if (r_busy) begin
            n_hist = hist_shift;
            n_code = code_step;
            if (hist_shift == DITHER_A || hist_shift == DITHER_B) begin
                n_busy = 1'b0;
                n_out  = '{regulator_out: r_active, trim_code: r_code, status: ST_PASS};
            end else if (r_cont_mode || r_count >= r_run_limit) begin
                n_busy = 1'b0;
                n_out  = '{regulator_out: r_active, trim_code: r_code, status: ST_FAIL};
            end else begin
                n_count = r_count + 1'b1;
                n_out   = '{regulator_out: r_active, trim_code: code_step, status: ST_RUN};
            end
        end
    end

    // advance state when the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_code   <= '0;
            r_hist   <= '0;
            r_count  <= '0;
            r_active <= '0;
        end else if (s1_move) begin
            r_busy   <= n_busy;
            r_code   <= n_code;
            r_hist   <= n_hist;
            r_count  <= n_count;
            r_active <= n_active;
        end
    end

    // load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_stall) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_regulator_out = r_out.regulator_out;
    assign o_trim_code     = r_out.trim_code;
    assign o_status        = r_out.status;

    // a finished result means no search is running behind it
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_PASS || r_out.status == ST_FAIL ||
                         r_out.status == ST_BYPASS)) |-> !r_busy)
        else $error("finished result while search still busy");

    // a running result means the search is live
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_RUN) |-> r_busy)
        else $error("running result without an active search");

    // the code never leaves its range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> (r_code <= TOP_CODE))
        else $error("trim code above top code");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> (r_out_valid && $stable(r_out)))
        else $error("result changed while stalled");

endmodule : regulator_trim_calibrator

`default_nettype wire
